### rtl/mapw_pkg.sv
// mapw_pkg: shared constants, codes, state type and control structs
// for the memory access profiler; no dependencies
package mapw_pkg;

   localparam int NUM_HANDLERS = 4;
   localparam int ADDR_BITS    = 16;
   localparam int COUNT_BITS   = 32;
   localparam int MEM_DEPTH    = 2 ** ADDR_BITS;
   localparam logic [2:0] MAX_LEN = 3'd4;

   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic [1:0] {
      OP_ACCESS   = 2'd0,
      OP_CLEAR    = 2'd1,
      OP_CLASSIFY = 2'd2,
      OP_TOTAL    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      HK_EXEC  = 2'd0,
      HK_READ  = 2'd1,
      HK_WRITE = 2'd2,
      HK_NEVER = 2'd3
   } hkind_type;

   localparam logic [1:0] BUS_READ  = 2'd1;
   localparam logic [1:0] BUS_WRITE = 2'd2;

   localparam logic [1:0] USE_UNKNOWN = 2'd0;
   localparam logic [1:0] USE_CODE    = 2'd1;
   localparam logic [1:0] USE_DATA    = 2'd2;

   localparam logic [2:0] CFG_ENABLES = 3'd0;
   localparam logic [2:0] CFG_BREAKS  = 3'd1;
   localparam logic [2:0] CFG_KINDS   = 3'd2;
   localparam logic [2:0] CFG_STARTS  = 3'd3;
   localparam logic [2:0] CFG_ENDS    = 3'd4;

   typedef enum logic [3:0] {
      ST_INIT_CLR,
      ST_IDLE,
      ST_DISPATCH,
      ST_EXEC_RD,
      ST_EXEC_WR,
      ST_BUS_RD,
      ST_BUS_WR,
      ST_SCAN,
      ST_CLS_RD,
      ST_CLS_CHK,
      ST_CLR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic exec_rd;
      logic exec_wr;
      logic bus_rd;
      logic bus_wr;
      logic scan;
      logic cls_rd;
      logic cls_chk;
      logic clr_start;
      logic clr_wr;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   len_zero;
      logic   exec_last;
      logic   clr_last;
      logic   rsp_free;
   } status_type;

endpackage

### rtl/mapw_ctrl.sv
// mapw_ctrl: sequencer for access, clear, classify and total operations
// depends on mapw_pkg
module mapw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mapw_pkg::status_type status,
   output mapw_pkg::cmd_type    cmd
);

   mapw_pkg::state_type st_ff, st_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= mapw_pkg::ST_INIT_CLR;
      end else begin
         st_ff <= st_in;
      end
   end

   always_comb begin
      st_in     = st_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (st_ff)
         mapw_pkg::ST_INIT_CLR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) st_in = mapw_pkg::ST_IDLE;
         end
         mapw_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               st_in    = mapw_pkg::ST_DISPATCH;
            end
         end
         mapw_pkg::ST_DISPATCH: begin
            case (status.op)
               mapw_pkg::OP_ACCESS:
                  st_in = status.len_zero ? mapw_pkg::ST_BUS_RD : mapw_pkg::ST_EXEC_RD;
               mapw_pkg::OP_CLEAR: begin
                  cmd.clr_start = 1'b1;
                  st_in         = mapw_pkg::ST_CLR;
               end
               mapw_pkg::OP_CLASSIFY: st_in = mapw_pkg::ST_CLS_RD;
               default:               st_in = mapw_pkg::ST_DONE;
            endcase
         end
         mapw_pkg::ST_EXEC_RD: begin
            cmd.exec_rd = 1'b1;
            st_in       = mapw_pkg::ST_EXEC_WR;
         end
         mapw_pkg::ST_EXEC_WR: begin
            cmd.exec_wr = 1'b1;
            st_in = status.exec_last ? mapw_pkg::ST_BUS_RD : mapw_pkg::ST_EXEC_RD;
         end
         mapw_pkg::ST_BUS_RD: begin
            cmd.bus_rd = 1'b1;
            st_in      = mapw_pkg::ST_BUS_WR;
         end
         mapw_pkg::ST_BUS_WR: begin
            cmd.bus_wr = 1'b1;
            st_in      = mapw_pkg::ST_SCAN;
         end
         mapw_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            st_in    = mapw_pkg::ST_DONE;
         end
         mapw_pkg::ST_CLS_RD: begin
            cmd.cls_rd = 1'b1;
            st_in      = mapw_pkg::ST_CLS_CHK;
         end
         mapw_pkg::ST_CLS_CHK: begin
            cmd.cls_chk = 1'b1;
            st_in       = mapw_pkg::ST_DONE;
         end
         mapw_pkg::ST_CLR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) st_in = mapw_pkg::ST_DONE;
         end
         mapw_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd.out_load = 1'b1;
               st_in        = mapw_pkg::ST_IDLE;
            end
         end
         default: st_in = mapw_pkg::ST_IDLE;
      endcase
   end

endmodule

### rtl/mapw_dp.sv
// mapw_dp: counter memories, handler registers and scan, result register
// depends on mapw_pkg
module mapw_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  mapw_pkg::cmd_type    cmd,
   output mapw_pkg::status_type status,
   input  logic [1:0]           req_opcode,
   input  logic [15:0]          req_pc_addr,
   input  logic [15:0]          req_bus_addr,
   input  logic [1:0]           req_bus_kind,
   input  logic [2:0]           req_instr_len,
   input  logic [1:0]           req_handler_sel,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_trap,
   output logic [3:0]           rsp_matched_mask,
   output logic [1:0]           rsp_use_class,
   output logic                 rsp_self_modified,
   output logic [31:0]          rsp_count_value,
   input  logic                 csr_valid,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_data
);

   localparam int NH = mapw_pkg::NUM_HANDLERS;

   mapw_pkg::count_type exec_mem  [mapw_pkg::MEM_DEPTH];
   mapw_pkg::count_type read_mem  [mapw_pkg::MEM_DEPTH];
   mapw_pkg::count_type write_mem [mapw_pkg::MEM_DEPTH];
   mapw_pkg::count_type exec_q_ff, read_q_ff, write_q_ff;
   mapw_pkg::count_type totals_ff [NH];

   logic [3:0]  enables_ff, breaks_ff;
   logic [7:0]  kinds_ff;
   logic [63:0] starts_ff, ends_ff;

   mapw_pkg::op_type   op_ff;
   mapw_pkg::addr_type pc_ff, addr_ff, clr_addr_ff, exec_addr;
   logic [1:0] kind_ff;
   logic [2:0] len_ff, idx_ff;

   logic       trap_w_ff, smc_w_ff, trap_hit;
   logic [3:0] mask_w_ff, hit_mask;
   logic [1:0] use_w_ff;
   mapw_pkg::count_type cnt_w_ff, cnt_sel;

   logic       rsp_valid_ff, rsp_trap_ff, rsp_smc_ff;
   logic [3:0] rsp_mask_ff;
   logic [1:0] rsp_use_ff;
   logic [31:0] rsp_cnt_ff;

   function automatic mapw_pkg::count_type sat_inc(input mapw_pkg::count_type v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         enables_ff <= '0;
         breaks_ff  <= '0;
         kinds_ff   <= '0;
         starts_ff  <= '0;
         ends_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            mapw_pkg::CFG_ENABLES: enables_ff <= csr_data[3:0];
            mapw_pkg::CFG_BREAKS:  breaks_ff  <= csr_data[3:0];
            mapw_pkg::CFG_KINDS:   kinds_ff   <= csr_data[7:0];
            mapw_pkg::CFG_STARTS:  starts_ff  <= csr_data;
            mapw_pkg::CFG_ENDS:    ends_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cnt_sel = '0;
      for (int h = 0; h < NH; h++) begin
         if (req_handler_sel == 2'(h)) cnt_sel = totals_ff[h];
      end
   end

   // item capture and exec byte index
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= mapw_pkg::op_type'(req_opcode);
         pc_ff   <= req_pc_addr[mapw_pkg::ADDR_BITS-1:0];
         addr_ff <= req_bus_addr[mapw_pkg::ADDR_BITS-1:0];
         kind_ff <= req_bus_kind;
         len_ff  <= (req_instr_len > mapw_pkg::MAX_LEN) ? mapw_pkg::MAX_LEN : req_instr_len;
         idx_ff  <= '0;
      end else if (cmd.exec_wr) begin
         idx_ff <= idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_start) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign exec_addr = pc_ff + mapw_pkg::ADDR_BITS'(idx_ff);

   // counter memories
   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         exec_mem[clr_addr_ff] <= '0;
      end else if (cmd.exec_wr) begin
         exec_mem[exec_addr] <= sat_inc(exec_q_ff);
      end
      if (cmd.exec_rd) begin
         exec_q_ff <= exec_mem[exec_addr];
      end else if (cmd.cls_rd) begin
         exec_q_ff <= exec_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         read_mem[clr_addr_ff] <= '0;
      end else if (cmd.bus_wr && kind_ff == mapw_pkg::BUS_READ) begin
         read_mem[addr_ff] <= sat_inc(read_q_ff);
      end
      if (cmd.bus_rd || cmd.cls_rd) read_q_ff <= read_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         write_mem[clr_addr_ff] <= '0;
      end else if (cmd.bus_wr && kind_ff == mapw_pkg::BUS_WRITE) begin
         write_mem[addr_ff] <= sat_inc(write_q_ff);
      end
      if (cmd.bus_rd || cmd.cls_rd) write_q_ff <= write_mem[addr_ff];
   end

   // handler scan in priority order, stopping at the first break hit
   always_comb begin
      logic [1:0]  hk;
      logic [15:0] a16, lo, hi;
      logic        hit, stop;
      hit_mask = '0;
      trap_hit = 1'b0;
      stop     = 1'b0;
      for (int h = 0; h < NH; h++) begin
         hk  = kinds_ff[2*h +: 2];
         lo  = starts_ff[16*h +: 16];
         hi  = ends_ff[16*h +: 16];
         a16 = 16'((hk == mapw_pkg::HK_EXEC) ? pc_ff : addr_ff);
         hit = enables_ff[h] && (a16 >= lo) && (a16 <= hi) &&
               ((hk == mapw_pkg::HK_EXEC) ||
                (hk == mapw_pkg::HK_READ && kind_ff == mapw_pkg::BUS_READ) ||
                (hk == mapw_pkg::HK_WRITE && kind_ff == mapw_pkg::BUS_WRITE));
         if (!stop && hit) begin
            hit_mask[h] = 1'b1;
            if (breaks_ff[h]) begin
               trap_hit = 1'b1;
               stop     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int h = 0; h < NH; h++) totals_ff[h] <= '0;
      end else if (cmd.scan) begin
         for (int h = 0; h < NH; h++) begin
            if (hit_mask[h]) totals_ff[h] <= sat_inc(totals_ff[h]);
         end
      end
   end

   // working result
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         trap_w_ff <= 1'b0;
         mask_w_ff <= '0;
         use_w_ff  <= mapw_pkg::USE_UNKNOWN;
         smc_w_ff  <= 1'b0;
         cnt_w_ff  <= (req_opcode == mapw_pkg::OP_TOTAL) ? cnt_sel : '0;
      end else if (cmd.scan) begin
         trap_w_ff <= trap_hit;
         mask_w_ff <= hit_mask;
      end else if (cmd.cls_chk) begin
         smc_w_ff <= (|exec_q_ff) && (|write_q_ff);
         if (|exec_q_ff) begin
            use_w_ff <= mapw_pkg::USE_CODE;
         end else if ((|read_q_ff) || (|write_q_ff)) begin
            use_w_ff <= mapw_pkg::USE_DATA;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_trap_ff <= trap_w_ff;
         rsp_mask_ff <= mask_w_ff;
         rsp_use_ff  <= use_w_ff;
         rsp_smc_ff  <= smc_w_ff;
         rsp_cnt_ff  <= 32'(cnt_w_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_trap          = rsp_trap_ff;
   assign rsp_matched_mask  = rsp_mask_ff;
   assign rsp_use_class     = rsp_use_ff;
   assign rsp_self_modified = rsp_smc_ff;
   assign rsp_count_value   = rsp_cnt_ff;

   assign status.op        = op_ff;
   assign status.len_zero  = (len_ff == 3'd0);
   assign status.exec_last = ((idx_ff + 3'd1) == len_ff);
   assign status.clr_last  = &clr_addr_ff;
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

endmodule

### rtl/memory_access_profiler_watchpoint.sv
// memory_access_profiler_watchpoint: top level, sequencer plus datapath
// depends on mapw_pkg, mapw_ctrl, mapw_dp
//
//  port group  direction  handshake          moves
//  req_*       in         valid / stall      one operation word
//  rsp_*       out        valid / stall      one result word per operation
//  csr_*       in         valid / ready      register index and data
//
// access: dispatch, then a read and a write per exec byte, then the bus counter
// read and write, the handler scan and the result hand-off (each counter bump
// is a read then write on a single-port memory); classify reads then checks.
// clear sweeps all 65536 entries, one a cycle.
// after reset the same sweep runs once with req_stall high.
// a stalled result waits in the output register; the next word is taken
// meanwhile and holds at its end until the register frees up.
module memory_access_profiler_watchpoint (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_pc_addr,
   input  logic [15:0] req_bus_addr,
   input  logic [1:0]  req_bus_kind,
   input  logic [2:0]  req_instr_len,
   input  logic [1:0]  req_handler_sel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_trap,
   output logic [3:0]  rsp_matched_mask,
   output logic [1:0]  rsp_use_class,
   output logic        rsp_self_modified,
   output logic [31:0] rsp_count_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   mapw_pkg::cmd_type    cmd;
   mapw_pkg::status_type status;

   assign csr_ready = 1'b1;

   mapw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mapw_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_pc_addr       (req_pc_addr),
      .req_bus_addr      (req_bus_addr),
      .req_bus_kind      (req_bus_kind),
      .req_instr_len     (req_instr_len),
      .req_handler_sel   (req_handler_sel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_trap          (rsp_trap),
      .rsp_matched_mask  (rsp_matched_mask),
      .rsp_use_class     (rsp_use_class),
      .rsp_self_modified (rsp_self_modified),
      .rsp_count_value   (rsp_count_value),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // one word in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted a word while another was in flight");

   a_trap_has_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_trap) |-> (rsp_matched_mask != 4'd0))
      else $error("trap without a matched handler");

   a_hit_no_class: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_matched_mask != 4'd0) |->
         (rsp_use_class == mapw_pkg::USE_UNKNOWN && rsp_count_value == 32'd0))
      else $error("access result carries classify or total fields");

   a_smc_is_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_self_modified) |-> (rsp_use_class == mapw_pkg::USE_CODE))
      else $error("self-modified flag on a non-code address");

endmodule

### test/testbench.sv
// testbench for memory_access_profiler_watchpoint: random and directed operation words,
// a cycle-free predictor of counters and watchpoint handlers, in-order result checking
// depends on mapw_pkg and the rtl top level
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      mapw_pkg::op_type op;
      logic [15:0] pc;
      logic [15:0] bus;
      logic [1:0]  kind;
      logic [2:0]  len;
      logic [1:0]  sel;
   } access_type;

   typedef struct {
      logic        trap;
      logic [3:0]  mask;
      logic [1:0]  use_class;
      logic        smc;
      logic [31:0] count;
   } verdict_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [15:0] req_pc_addr = '0;
   logic [15:0] req_bus_addr = '0;
   logic [1:0]  req_bus_kind = '0;
   logic [2:0]  req_instr_len = '0;
   logic [1:0]  req_handler_sel = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_trap;
   logic [3:0]  rsp_matched_mask;
   logic [1:0]  rsp_use_class;
   logic        rsp_self_modified;
   logic [31:0] rsp_count_value;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   memory_access_profiler_watchpoint dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // predictor state
   bit [31:0]   exec_cnt [mapw_pkg::MEM_DEPTH];
   bit [31:0]   read_cnt [mapw_pkg::MEM_DEPTH];
   bit [31:0]   write_cnt [mapw_pkg::MEM_DEPTH];
   bit [31:0]   totals [mapw_pkg::NUM_HANDLERS];
   logic [3:0]  enables = '0, breaks = '0;
   logic [7:0]  kinds = '0;
   logic [63:0] starts = '0, ends = '0;

   logic [15:0] probe_addrs [8] = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0010, 16'h0020,
                                    16'h0203, 16'h0204, 16'h1234};

   access_type  pending_words[$];
   verdict_type expected[$];
   int       failures = 0;
   int       results_seen = 0;
   bit       idle_on = 1;

   function automatic bit [31:0] sat_inc(bit [31:0] c);
      return (c == '1) ? c : c + 1;
   endfunction

   function automatic void add_word(access_type w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   function automatic verdict_type profile(access_type a);
      verdict_type v;
      int       n;
      bit       rd, wr, hit;
      logic [1:0]  hk;
      logic [15:0] lo, hi, ad;
      v = '{default: '0};
      case (a.op)
         mapw_pkg::OP_ACCESS: begin
            rd = (a.kind == mapw_pkg::BUS_READ);
            wr = (a.kind == mapw_pkg::BUS_WRITE);
            n = (a.len > mapw_pkg::MAX_LEN) ? int'(mapw_pkg::MAX_LEN) : int'(a.len);
            for (int i = 0; i < n; i++)
               exec_cnt[16'(a.pc + i)] = sat_inc(exec_cnt[16'(a.pc + i)]);
            if (rd) read_cnt[a.bus] = sat_inc(read_cnt[a.bus]);
            if (wr) write_cnt[a.bus] = sat_inc(write_cnt[a.bus]);
            for (int h = 0; h < mapw_pkg::NUM_HANDLERS; h++) begin
               hk = kinds[2*h +: 2];
               lo = starts[16*h +: 16];
               hi = ends[16*h +: 16];
               ad = (hk == mapw_pkg::HK_EXEC) ? a.pc : a.bus;
               hit = enables[h] && ad >= lo && ad <= hi &&
                     (hk == mapw_pkg::HK_EXEC || (hk == mapw_pkg::HK_READ && rd) ||
                      (hk == mapw_pkg::HK_WRITE && wr));
               if (hit) begin
                  totals[h] = sat_inc(totals[h]);
                  v.mask[h] = 1;
                  if (breaks[h]) begin
                     v.trap = 1;
                     break;
                  end
               end
            end
         end
         mapw_pkg::OP_CLEAR: begin
            for (int i = 0; i < mapw_pkg::MEM_DEPTH; i++) begin
               exec_cnt[i] = 0;
               read_cnt[i] = 0;
               write_cnt[i] = 0;
            end
         end
         mapw_pkg::OP_CLASSIFY: begin
            v.smc = exec_cnt[a.bus] != 0 && write_cnt[a.bus] != 0;
            if (exec_cnt[a.bus] != 0) v.use_class = mapw_pkg::USE_CODE;
            else if (read_cnt[a.bus] != 0 || write_cnt[a.bus] != 0)
               v.use_class = mapw_pkg::USE_DATA;
            else v.use_class = mapw_pkg::USE_UNKNOWN;
         end
         default: v.count = (a.sel < mapw_pkg::NUM_HANDLERS) ? totals[a.sel] : '0;
      endcase
      return v;
   endfunction

   // driver
   int gap_left = 0;
   always @(posedge clock) begin
      access_type w;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            w.op = mapw_pkg::op_type'(req_opcode);
            w.pc = req_pc_addr;
            w.bus = req_bus_addr;
            w.kind = req_bus_kind;
            w.len = req_instr_len;
            w.sel = req_handler_sel;
            expected.insert(expected.size(), profile(w));
            gap_left = idle_on ? $urandom_range(0, 8) : 0;
         end
         if (req_valid && req_stall) begin
            // hold the stalled word
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 0;
         end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            req_opcode <= w.op;
            req_pc_addr <= w.pc;
            req_bus_addr <= w.bus;
            req_bus_kind <= w.kind;
            req_instr_len <= w.len;
            req_handler_sel <= w.sel;
            req_valid <= 1;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // monitor
   int stall_left = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      verdict_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected.size() == 0) begin
               $display("%0t: unexpected word trap=%0b mask=%h", $time, rsp_trap,
                        rsp_matched_mask);
               failures++;
            end else begin
               e = expected.pop_front();
               if (rsp_trap !== e.trap) begin
                  $display("%0t: trap expected %0b actual %0b", $time, e.trap, rsp_trap);
                  failures++;
               end
               if (rsp_matched_mask !== e.mask) begin
                  $display("%0t: matched_mask expected %h actual %h", $time, e.mask,
                           rsp_matched_mask);
                  failures++;
               end
               if (rsp_use_class !== e.use_class) begin
                  $display("%0t: use_class expected %0d actual %0d", $time, e.use_class,
                           rsp_use_class);
                  failures++;
               end
               if (rsp_self_modified !== e.smc) begin
                  $display("%0t: self_modified expected %0b actual %0b", $time, e.smc,
                           rsp_self_modified);
                  failures++;
               end
               if (rsp_count_value !== e.count) begin
                  $display("%0t: count_value expected %0d actual %0d", $time, e.count,
                           rsp_count_value);
                  failures++;
               end
            end
            stall_left = idle_on ? $urandom_range(0, 8) : 0;
            // one long hold-off so the block backs up into its input
            if (results_seen == 150) hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   task automatic wait_idle();
      while (pending_words.size() > 0 || req_valid || expected.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [63:0] d);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         mapw_pkg::CFG_ENABLES: enables = d[3:0];
         mapw_pkg::CFG_BREAKS:  breaks = d[3:0];
         mapw_pkg::CFG_KINDS:   kinds = d[7:0];
         mapw_pkg::CFG_STARTS:  starts = d;
         mapw_pkg::CFG_ENDS:    ends = d;
         default: ;
      endcase
   endtask

   task automatic configure(logic [3:0] en, logic [3:0] br, logic [7:0] kd,
                            logic [63:0] st, logic [63:0] en_d);
      write_reg(mapw_pkg::CFG_ENABLES, 64'(en));
      write_reg(mapw_pkg::CFG_BREAKS, 64'(br));
      write_reg(mapw_pkg::CFG_KINDS, 64'(kd));
      write_reg(mapw_pkg::CFG_STARTS, st);
      write_reg(mapw_pkg::CFG_ENDS, en_d);
   endtask

   function automatic logic [15:0] pick_addr();
      case ($urandom_range(0, 9))
         0:       return 16'($urandom);
         1, 2:    return 16'hFFF0 + 16'($urandom_range(0, 15));
         default: return 16'($urandom_range(0, 31));
      endcase
   endfunction

   function automatic access_type word(mapw_pkg::op_type op, logic [15:0] pc,
                                       logic [15:0] bus, logic [1:0] kind,
                                       logic [2:0] len, logic [1:0] sel);
      access_type w;
      w.op = op; w.pc = pc; w.bus = bus; w.kind = kind; w.len = len; w.sel = sel;
      return w;
   endfunction

   function automatic access_type random_word();
      int r;
      r = $urandom_range(0, 99);
      return word(r < 60 ? mapw_pkg::OP_ACCESS :
                  (r < 85 ? mapw_pkg::OP_CLASSIFY : mapw_pkg::OP_TOTAL), pick_addr(),
                  pick_addr(), 2'($urandom), 3'($urandom), 2'($urandom));
   endfunction

   task automatic random_config();
      logic [63:0] st, en_d;
      logic [15:0] lo;
      for (int h = 0; h < 4; h++) begin
         lo = pick_addr();
         st[16*h +: 16] = lo;
         // an occasional empty range
         en_d[16*h +: 16] = ($urandom_range(0, 7) == 0) ?
                            16'(lo - 16'd1 - 16'($urandom_range(0, 3))) :
                            16'(lo + 16'($urandom_range(0, 20)));
      end
      configure(4'($urandom), 4'($urandom), 8'($urandom), st, en_d);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;

      // directed: h0 exec near top, h1 read anywhere, h2 write low window and breaks
      configure(4'hF, 4'b0100,
                {mapw_pkg::HK_NEVER, mapw_pkg::HK_WRITE, mapw_pkg::HK_READ,
                 mapw_pkg::HK_EXEC},
                {16'h0000, 16'h0010, 16'h0000, 16'hFFFE},
                {16'hFFFF, 16'h0020, 16'hFFFF, 16'hFFFF});
      add_word(word(mapw_pkg::OP_ACCESS, 16'hFFFF, 16'h0010, mapw_pkg::BUS_WRITE, 3'd4,
                    2'd0));
      add_word(word(mapw_pkg::OP_ACCESS, 16'h0100, 16'h0020, mapw_pkg::BUS_READ, 3'd0,
                    2'd0));
      add_word(word(mapw_pkg::OP_ACCESS, 16'h0200, 16'hFFFF, 2'd3, 3'd7, 2'd0));
      add_word(word(mapw_pkg::OP_ACCESS, 16'hFFFE, 16'h0000, 2'd0, 3'd1, 2'd0));
      add_word(word(mapw_pkg::OP_ACCESS, 16'h0001, 16'h0001, mapw_pkg::BUS_WRITE, 3'd2,
                    2'd0));
      add_word(word(mapw_pkg::OP_ACCESS, 16'h0000, 16'h0011, mapw_pkg::BUS_WRITE, 3'd3,
                    2'd3));
      foreach (probe_addrs[i])
         add_word(word(mapw_pkg::OP_CLASSIFY, 16'hFFFF, probe_addrs[i], 2'd3, 3'd7, 2'd3));
      for (int s = 0; s < 4; s++)
         add_word(word(mapw_pkg::OP_TOTAL, 16'hFFFF, 16'hFFFF, 2'd3, 3'd7, 2'(s)));
      add_word(word(mapw_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 2'd3, 3'd7, 2'd3));
      add_word(word(mapw_pkg::OP_CLASSIFY, 16'h0000, 16'h0010, 2'd0, 3'd0, 2'd0));
      add_word(word(mapw_pkg::OP_CLASSIFY, 16'h0000, 16'h0000, 2'd0, 3'd0, 2'd0));
      add_word(word(mapw_pkg::OP_TOTAL, 16'h0000, 16'h0000, 2'd0, 3'd0, 2'd2));
      wait_idle();

      // extremes: all handlers on over the full space as never-match breaks, then as exec handlers without breaks
      configure(4'hF, 4'hF, 8'hFF, 64'h0, '1);
      for (int i = 0; i < 20; i++) add_word(random_word());
      wait_idle();
      configure(4'hF, 4'h0, 8'h00, 64'h0, '1);
      for (int i = 0; i < 20; i++) add_word(random_word());
      wait_idle();

      for (int p = 0; p < 10; p++) begin
         random_config();
         idle_on = (p % 4 != 3);
         if (p == 3 || p == 7) add_word(word(mapw_pkg::OP_CLEAR, pick_addr(),
            pick_addr(), 2'($urandom), 3'($urandom), 2'($urandom)));
         for (int i = 0; i < 50; i++) add_word(random_word());
         // each phase ends with the sender paused until everything is back
         wait_idle();
      end
      idle_on = 1;
      configure(4'h0, 4'h0, 8'h00, 64'h0, 64'h0);
      for (int i = 0; i < 10; i++) add_word(random_word());
      wait_idle();

      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("FAIL");
      $finish;
   end

endmodule

### sim.f
rtl/mapw_pkg.sv
rtl/mapw_ctrl.sv
rtl/mapw_dp.sv
rtl/memory_access_profiler_watchpoint.sv
test/testbench.sv
